// ===== rtl/pea_pkg.sv =====
package pea_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int PAGE_BYTES  = 4096;

  localparam int IDX_W  = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int LIVE_W = $clog2(MAX_EXTENTS + 1);
  // merged size: sum of up to MAX_EXTENTS 32-bit sizes
  localparam int ZW     = 32 + $clog2(MAX_EXTENTS + 1);

  localparam logic [0:0] OP_ALLOC = 1'b0;
  localparam logic [0:0] OP_FREE  = 1'b1;

  localparam logic [1:0] STRAT_BUMP  = 2'd0;
  localparam logic [1:0] STRAT_FIRST = 2'd1;
  localparam logic [1:0] STRAT_NEXT  = 2'd2;
  localparam logic [1:0] STRAT_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] REG_STRATEGY   = 2'd0;
  localparam logic [1:0] REG_HEAP_START = 2'd1;
  localparam logic [1:0] REG_HEAP_END   = 2'd2;

  localparam logic [31:0] HEAP_START_RST = 32'd4127195136;
  localparam logic [31:0] HEAP_END_RST   = 32'd4294963200;

  // one taken record and one free record per cell
  typedef struct packed {
    logic        tv;
    logic [31:0] ts;
    logic [31:0] tz;
    logic        fv;
    logic [31:0] fs;
    logic [31:0] fz;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } ring_ctl_t;

endpackage

// ===== rtl/pea_cell.sv =====
module pea_cell import pea_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ring_ctl_t ring_i,
  input  entry_t    init_i,
  input  entry_t    nxt_i,
  output entry_t    ent_o
);

  logic   tv_q, fv_q;
  entry_t dat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= 1'b0;
      fv_q <= 1'b0;
    end else if (ring_i.clr) begin
      tv_q <= init_i.tv;
      fv_q <= init_i.fv;
    end else if (ring_i.shift) begin
      tv_q <= nxt_i.tv;
      fv_q <= nxt_i.fv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_i.clr) begin
      dat_q <= init_i;
    end else if (ring_i.shift) begin
      dat_q <= nxt_i;
    end
  end

  always_comb begin
    ent_o    = dat_q;
    ent_o.tv = tv_q;
    ent_o.fv = fv_q;
  end

endmodule

// ===== rtl/pea_ctrl.sv =====
module pea_ctrl import pea_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] size_bytes_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] start_address_o,
  output logic [1:0]  status_o,
  input  entry_t      head_i,
  output entry_t      wb_o,
  output entry_t      init_o,
  output ring_ctl_t   ring_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_AFIND  = 8'b0000_0010,
    S_ADEC   = 8'b0000_0100,
    S_AAPPLY = 8'b0000_1000,
    S_FFIND  = 8'b0001_0000,
    S_FMERGE = 8'b0010_0000,
    S_FINS   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [1:0]         strat_q, strat_d;
  logic [31:0]        hs_q, hs_d, he_q, he_d;
  logic               pend_q, pend_d;
  logic [31:0]        pp_q, pp_d;
  logic [LIVE_W-1:0]  live_q, live_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [31:0]        sz_q, sz_d, addr_q, addr_d;
  logic               pick_v_q, pick_v_d, below_v_q, below_v_d, slot_v_q, slot_v_d;
  logic [IDX_W-1:0]   pick_i_q, pick_i_d, below_i_q, below_i_d, slot_i_q, slot_i_d;
  logic [IDX_W-1:0]   cho_i_q, cho_i_d;
  logic [31:0]        pick_s_q, pick_s_d, below_s_q, below_s_d;
  logic [31:0]        s_q, s_d;
  logic [ZW-1:0]      z_q, z_d;
  logic               hit_q, hit_d;
  logic [31:0]        res_addr_q, res_addr_d;
  logic [1:0]         res_st_q, res_st_d;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        out_addr_q, out_addr_d;
  logic [1:0]         out_st_q, out_st_d;

  logic [32:0]        rsum, rsz;
  logic               bad, last, acc, match, inc, dec;
  logic [ZW:0]        end_sum;
  logic [32:0]        fend;
  logic [31:0]        cho_s;
  logic [IDX_W-1:0]   cho_i;
  logic               cho_v;
  logic [31:0]        new_fz;

  assign in_ready_o      = (state_q == S_IDLE) && !pend_q;
  assign acc             = in_valid_i && in_ready_o;
  assign out_valid_o     = out_valid_q;
  assign start_address_o = out_addr_q;
  assign status_o        = out_st_q;

  // round up to whole pages
  assign rsum = {1'b0, size_bytes_i} + 33'(PAGE_BYTES - 1);
  assign rsz  = rsum & ~33'(PAGE_BYTES - 1);
  assign bad  = (rsz == 33'd0) || rsz[32] || (strat_q == STRAT_RSVD);
  assign last = (idx_q == IDX_W'(MAX_EXTENTS - 1));

  assign end_sum = {1'b0, ZW'(s_q)} + {1'b0, z_q};
  assign fend    = {1'b0, head_i.fs} + {1'b0, head_i.fz};
  assign new_fz  = head_i.fz - sz_q;

  assign cho_v = pick_v_q || below_v_q;
  assign cho_s = pick_v_q ? pick_s_q : below_s_q;
  assign cho_i = pick_v_q ? pick_i_q : below_i_q;

  always_comb begin
    init_o    = '0;
    init_o.fs = hs_q;
    init_o.fz = (he_q > hs_q) ? (he_q - hs_q) : 32'd0;
    init_o.fv = (init_o.fz != 32'd0);
  end

  always_comb begin
    state_d     = state_q;
    strat_d     = strat_q;
    hs_d        = hs_q;
    he_d        = he_q;
    pend_d      = pend_q;
    pp_d        = pp_q;
    live_d      = live_q;
    idx_d       = idx_q;
    sz_d        = sz_q;
    addr_d      = addr_q;
    pick_v_d    = pick_v_q;
    pick_i_d    = pick_i_q;
    pick_s_d    = pick_s_q;
    below_v_d   = below_v_q;
    below_i_d   = below_i_q;
    below_s_d   = below_s_q;
    slot_v_d    = slot_v_q;
    slot_i_d    = slot_i_q;
    cho_i_d     = cho_i_q;
    s_d         = s_q;
    z_d         = z_q;
    hit_d       = hit_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_st_d    = out_st_q;
    wb_o        = head_i;
    ring_o      = '0;
    match       = 1'b0;
    inc         = 1'b0;
    dec         = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (state_q != S_IDLE && state_q != S_ADEC && state_q != S_DONE) begin
      ring_o.shift = 1'b1;
      idx_d        = last ? '0 : idx_q + 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (pend_q) begin
          ring_o.clr = 1'b1;
          pp_d       = hs_q;
          live_d     = init_o.fv ? LIVE_W'(1) : '0;
          pend_d     = 1'b0;
        end else if (acc) begin
          idx_d = '0;
          hit_d = 1'b0;
          if (opcode_i == OP_FREE) begin
            addr_d  = address_i;
            state_d = S_FFIND;
          end else if (bad) begin
            res_addr_d = '0;
            res_st_d   = ST_NOFIT;
            state_d    = S_DONE;
          end else begin
            sz_d      = rsz[31:0];
            pick_v_d  = 1'b0;
            below_v_d = 1'b0;
            slot_v_d  = 1'b0;
            state_d   = S_AFIND;
          end
        end
      end
      S_AFIND: begin
        if (strat_q != STRAT_BUMP && head_i.fv && head_i.fz >= sz_q) begin
          if (strat_q == STRAT_NEXT && head_i.fs < pp_q) begin
            if (!below_v_q || head_i.fs < below_s_q) begin
              below_v_d = 1'b1;
              below_i_d = idx_q;
              below_s_d = head_i.fs;
            end
          end else if (!pick_v_q || head_i.fs < pick_s_q) begin
            pick_v_d = 1'b1;
            pick_i_d = idx_q;
            pick_s_d = head_i.fs;
          end
        end
        if (!head_i.tv && !slot_v_q) begin
          slot_v_d = 1'b1;
          slot_i_d = idx_q;
        end
        if (last) begin
          state_d = S_ADEC;
        end
      end
      S_ADEC: begin
        res_addr_d = '0;
        state_d    = S_DONE;
        if (strat_q == STRAT_BUMP) begin
          if (pp_q > he_q || sz_q > he_q - pp_q) begin
            res_st_d = ST_NOFIT;
          end else if (live_q >= LIVE_W'(MAX_EXTENTS) || !slot_v_q) begin
            res_st_d = ST_FULL;
          end else begin
            res_addr_d = pp_q;
            pp_d       = pp_q + sz_q;
            state_d    = S_AAPPLY;
          end
        end else if (!cho_v) begin
          res_st_d = ST_NOFIT;
        end else if (live_q >= LIVE_W'(MAX_EXTENTS) || !slot_v_q) begin
          res_st_d = ST_FULL;
        end else begin
          res_addr_d = cho_s;
          cho_i_d    = cho_i;
          pp_d       = (strat_q == STRAT_FIRST) ? pp_q + sz_q : cho_s;
          state_d    = S_AAPPLY;
        end
      end
      S_AAPPLY: begin
        if (idx_q == slot_i_q) begin
          wb_o.tv = 1'b1;
          wb_o.ts = res_addr_q;
          wb_o.tz = sz_q;
          inc     = 1'b1;
        end
        if (strat_q != STRAT_BUMP && idx_q == cho_i_q) begin
          wb_o.fs = head_i.fs + sz_q;
          wb_o.fz = new_fz;
          if (new_fz == 32'd0) begin
            wb_o.fv = 1'b0;
            dec     = 1'b1;
          end
        end
        live_d = live_q + LIVE_W'(inc) - LIVE_W'(dec);
        if (last) begin
          res_st_d = ST_OK;
          state_d  = S_DONE;
        end
      end
      S_FFIND: begin
        if (!hit_q && head_i.tv && head_i.ts == addr_q) begin
          match   = 1'b1;
          wb_o.tv = 1'b0;
          hit_d   = 1'b1;
          s_d     = head_i.ts;
          z_d     = ZW'(head_i.tz);
          live_d  = live_q - 1'b1;
        end
        if (last) begin
          hit_d = 1'b0;
          if (hit_q || match) begin
            state_d = S_FMERGE;
          end else begin
            res_addr_d = '0;
            res_st_d   = ST_NOTFOUND;
            state_d    = S_DONE;
          end
        end
      end
      S_FMERGE: begin
        // one merge per pass, lowest entry first, then rescan
        if (!hit_q && head_i.fv) begin
          if (end_sum == (ZW + 1)'(head_i.fs)) begin
            match = 1'b1;
            z_d   = z_q + ZW'(head_i.fz);
          end else if (fend == {1'b0, s_q}) begin
            match = 1'b1;
            s_d   = head_i.fs;
            z_d   = z_q + ZW'(head_i.fz);
          end
          if (match) begin
            wb_o.fv = 1'b0;
            hit_d   = 1'b1;
            live_d  = live_q - 1'b1;
          end
        end
        if (last) begin
          hit_d = 1'b0;
          if (!(hit_q || match)) begin
            state_d = S_FINS;
            if (strat_q == STRAT_NEXT && s_q < pp_q) begin
              pp_d = s_q;
            end
          end
        end
      end
      S_FINS: begin
        if (!hit_q && !head_i.fv) begin
          wb_o.fv = 1'b1;
          wb_o.fs = s_q;
          wb_o.fz = (|z_q[ZW-1:32]) ? 32'hFFFF_FFFF : z_q[31:0];
          hit_d   = 1'b1;
          live_d  = live_q + 1'b1;
        end
        if (last) begin
          res_addr_d = '0;
          res_st_d   = ST_OK;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STRATEGY: begin
          strat_d = cfg_data_i[1:0];
        end
        REG_HEAP_START: begin
          hs_d   = cfg_data_i;
          pend_d = 1'b1;
        end
        REG_HEAP_END: begin
          he_d   = cfg_data_i;
          pend_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      strat_q     <= STRAT_BUMP;
      hs_q        <= HEAP_START_RST;
      he_q        <= HEAP_END_RST;
      pend_q      <= 1'b1;
      pp_q        <= '0;
      live_q      <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      pick_v_q    <= 1'b0;
      below_v_q   <= 1'b0;
      slot_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      strat_q     <= strat_d;
      hs_q        <= hs_d;
      he_q        <= he_d;
      pend_q      <= pend_d;
      pp_q        <= pp_d;
      live_q      <= live_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      pick_v_q    <= pick_v_d;
      below_v_q   <= below_v_d;
      slot_v_q    <= slot_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sz_q       <= sz_d;
    addr_q     <= addr_d;
    pick_i_q   <= pick_i_d;
    pick_s_q   <= pick_s_d;
    below_i_q  <= below_i_d;
    below_s_q  <= below_s_d;
    slot_i_q   <= slot_i_d;
    cho_i_q    <= cho_i_d;
    s_q        <= s_d;
    z_q        <= z_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    out_addr_q <= out_addr_d;
    out_st_q   <= out_st_d;
  end

endmodule

// ===== rtl/page_extent_allocator.sv =====
// channel | direction | handshake                | payload
// cfg     | in        | cfg_we_i (no wait)       | cfg_idx_i, cfg_data_i
// request | in        | in_valid_i / in_ready_o  | opcode_i, size_bytes_i, address_i
// result  | out       | out_valid_o / out_ready_i| start_address_o, status_o
//
// records rotate through a ring of N = 64 cells, one record per cycle past the head.
// allocate: a search pass, a decision step, then an apply pass when placed; no fit or a full
// table ends at the decision step; a rejected size or mode goes straight to the result.
// free: a find pass, then if found merge passes (one extra per merge) and an insert pass.
// after reset or a heap_start/heap_end write the tables are rebuilt before new requests.
// a result waiting in the output register stalls the block only when the next result is ready.
module page_extent_allocator import pea_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] size_bytes_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] start_address_o,
  output logic [1:0]  status_o
);

  entry_t    ent [MAX_EXTENTS];
  entry_t    wb, init;
  ring_ctl_t ring;

  pea_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .size_bytes_i    (size_bytes_i),
    .address_i       (address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .start_address_o (start_address_o),
    .status_o        (status_o),
    .head_i          (ent[0]),
    .wb_o            (wb),
    .init_o          (init),
    .ring_o          (ring)
  );

  // cell 0 is the head; the updated head record re-enters at the tail
  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    if (i == MAX_EXTENTS - 1) begin : g_tail
      pea_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ring_i (ring),
        .init_i ((i == 0) ? init : entry_t'('0)),
        .nxt_i  (wb),
        .ent_o  (ent[i])
      );
    end else begin : g_body
      pea_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ring_i (ring),
        .init_i ((i == 0) ? init : entry_t'('0)),
        .nxt_i  (ent[i+1]),
        .ent_o  (ent[i])
      );
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import pea_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = OP_ALLOC;
  logic [31:0] size_bytes_i = '0;
  logic [31:0] address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] start_address_o;
  logic [1:0]  status_o;

  page_extent_allocator i_dut (.*);

  always #5 clk_i = ~clk_i;

  typedef struct {
    logic [31:0] addr;
    logic [1:0]  st;
  } grant_t;

  grant_t pending_grants[$];

  // allocator image kept by the testbench
  logic [1:0]  mdl_strategy;
  logic [31:0] mdl_heap_lo, mdl_heap_hi;
  logic [31:0] tk_start[MAX_EXTENTS], tk_size[MAX_EXTENTS];
  logic        tk_valid[MAX_EXTENTS];
  logic [31:0] fr_start[MAX_EXTENTS], fr_size[MAX_EXTENTS];
  logic        fr_valid[MAX_EXTENTS];
  logic [31:0] cursor;
  int unsigned record_count;

  int unsigned mismatches = 0, results_seen = 0;
  int unsigned n_grant = 0, n_nofit = 0, n_full = 0, n_notfound = 0, n_free_ok = 0;
  bit          calm = 1'b0;

  function automatic void rebuild_heap();
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      tk_valid[i] = 1'b0;
      fr_valid[i] = 1'b0;
      fr_start[i] = '0;
      fr_size[i]  = '0;
    end
    fr_start[0]  = mdl_heap_lo;
    fr_size[0]   = (mdl_heap_hi > mdl_heap_lo) ? mdl_heap_hi - mdl_heap_lo : 32'd0;
    fr_valid[0]  = fr_size[0] != 0;
    record_count = fr_valid[0] ? 1 : 0;
    cursor       = mdl_heap_lo;
  endfunction

  function automatic void predict_alloc(input logic [31:0] req, output grant_t g);
    logic [63:0] sz;
    logic [31:0] s;
    int pick, below, slot;
    pick = -1;
    below = -1;
    slot = -1;
    g.addr = '0;
    g.st = ST_NOFIT;
    sz = ({32'd0, req} + PAGE_BYTES - 1) / PAGE_BYTES * PAGE_BYTES;
    if (sz == 0 || sz > 64'hFFFF_FFFF || mdl_strategy == STRAT_RSVD) return;
    s = sz[31:0];
    if (mdl_strategy == STRAT_BUMP) begin
      if (cursor > mdl_heap_hi || s > mdl_heap_hi - cursor) return;
    end else begin
      for (int i = 0; i < MAX_EXTENTS; i++) begin
        if (!fr_valid[i] || fr_size[i] < s) continue;
        if (mdl_strategy == STRAT_NEXT && fr_start[i] < cursor) begin
          if (below < 0 || fr_start[i] < fr_start[below]) below = i;
        end else if (pick < 0 || fr_start[i] < fr_start[pick]) begin
          pick = i;
        end
      end
      if (pick < 0) pick = below;
      if (pick < 0) return;
    end
    for (int i = 0; i < MAX_EXTENTS; i++)
      if (!tk_valid[i] && slot < 0) slot = i;
    if (record_count >= MAX_EXTENTS || slot < 0) begin
      g.st = ST_FULL;
      return;
    end
    if (mdl_strategy == STRAT_BUMP) begin
      g.addr = cursor;
      cursor = cursor + s;
    end else begin
      g.addr = fr_start[pick];
      fr_start[pick] = fr_start[pick] + s;
      fr_size[pick] = fr_size[pick] - s;
      if (fr_size[pick] == 0) begin
        fr_valid[pick] = 1'b0;
        record_count--;
      end
      if (mdl_strategy == STRAT_FIRST) cursor = cursor + s;
      else cursor = g.addr;
    end
    tk_start[slot] = g.addr;
    tk_size[slot] = s;
    tk_valid[slot] = 1'b1;
    record_count++;
    g.st = ST_OK;
  endfunction

  function automatic void predict_release(input logic [31:0] a, output grant_t g);
    logic [63:0] s, z;
    int t, slot;
    bit merged;
    t = -1;
    slot = -1;
    merged = 1'b1;
    g.addr = '0;
    g.st = ST_NOTFOUND;
    for (int i = 0; i < MAX_EXTENTS; i++)
      if (t < 0 && tk_valid[i] && tk_start[i] == a) t = i;
    if (t < 0) return;
    s = {32'd0, tk_start[t]};
    z = {32'd0, tk_size[t]};
    tk_valid[t] = 1'b0;
    record_count--;
    while (merged) begin
      merged = 1'b0;
      for (int i = 0; i < MAX_EXTENTS; i++) begin
        if (merged || !fr_valid[i]) continue;
        if (s + z == {32'd0, fr_start[i]}) begin
          z = z + fr_size[i];
          merged = 1'b1;
        end else if ({32'd0, fr_start[i]} + fr_size[i] == s) begin
          s = {32'd0, fr_start[i]};
          z = z + fr_size[i];
          merged = 1'b1;
        end
        if (merged) begin
          fr_valid[i] = 1'b0;
          record_count--;
        end
      end
    end
    if (z > 64'hFFFF_FFFF) z = 64'hFFFF_FFFF;
    if (mdl_strategy == STRAT_NEXT && s[31:0] < cursor) cursor = s[31:0];
    for (int i = 0; i < MAX_EXTENTS; i++)
      if (slot < 0 && !fr_valid[i]) slot = i;
    if (slot >= 0) begin
      fr_start[slot] = s[31:0];
      fr_size[slot] = z[31:0];
      fr_valid[slot] = 1'b1;
      record_count++;
    end
    g.st = ST_OK;
  endfunction

  task automatic send_request(input logic op, input logic [31:0] sz, input logic [31:0] a);
    grant_t g;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    opcode_i     <= op;
    size_bytes_i <= sz;
    address_i    <= a;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_ALLOC) predict_alloc(sz, g);
    else predict_release(a, g);
    case (g.st)
      ST_OK:    if (op == OP_ALLOC) n_grant++; else n_free_ok++;
      ST_NOFIT: n_nofit++;
      ST_FULL:  n_full++;
      default:  n_notfound++;
    endcase
    pending_grants.push_back(g);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == REG_STRATEGY) begin
      mdl_strategy = data[1:0];
    end else begin
      if (idx == REG_HEAP_START) mdl_heap_lo = data;
      else mdl_heap_hi = data;
      rebuild_heap();
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_heap(input logic [31:0] lo, input logic [31:0] hi);
    write_reg(REG_HEAP_START, lo);
    write_reg(REG_HEAP_END, hi);
  endtask

  // small heaps keep the record table busy
  task automatic set_small_heap();
    logic [31:0] lo;
    lo = $urandom_range(0, 32'hFFF00) << 12;
    set_heap(lo, lo + ($urandom_range(24, 120) << 12) + ($urandom_range(0, 1) ? 0 :
             $urandom_range(0, 4095)));
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1:       return $urandom;
      2:       return 32'hFFFF_F000 + $urandom_range(0, 4095);
      3:       return $urandom_range(9, 40) * PAGE_BYTES - $urandom_range(0, 4095);
      default: return $urandom_range(1, 8) * PAGE_BYTES - $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic logic [31:0] pick_release_addr();
    int live[$];
    for (int i = 0; i < MAX_EXTENTS; i++)
      if (tk_valid[i]) live.push_back(i);
    if (live.size() == 0 || $urandom_range(0, 7) == 0)
      return $urandom_range(0, 1) ? $urandom : cursor;
    return tk_start[live[$urandom_range(0, live.size() - 1)]];
  endfunction

  task automatic random_traffic(input int n, input int alloc_pct);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < alloc_pct) send_request(OP_ALLOC, pick_size(), $urandom);
      else send_request(OP_FREE, $urandom, pick_release_addr());
    end
  endtask

  task automatic test_corner_requests();
    send_request(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_ALLOC, 32'hFFFF_F001, 32'd0);
    send_request(OP_ALLOC, 32'd1, 32'd0);
    send_request(OP_FREE, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_FREE, 32'd0, HEAP_START_RST);
    write_reg(REG_STRATEGY, 32'(STRAT_RSVD));
    send_request(OP_ALLOC, 32'd4096, 32'd0);
    // bounds crossed: empty heap
    set_heap(32'h0000_2000, 32'h0000_1000);
    write_reg(REG_STRATEGY, 32'(STRAT_FIRST));
    send_request(OP_ALLOC, 32'd4096, 32'd0);
    send_request(OP_FREE, 32'd0, 32'h0000_2000);
    // whole address space
    set_heap(32'd0, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'hFFFF_F000, 32'd0);
    send_request(OP_ALLOC, 32'h0000_1000, 32'd0);
    send_request(OP_FREE, 32'd0, 32'd0);
    write_reg(REG_STRATEGY, 32'(STRAT_NEXT));
    send_request(OP_ALLOC, 32'h0000_0FFF, 32'd0);
    send_request(OP_ALLOC, 32'h0000_2001, 32'd0);
    send_request(OP_FREE, 32'd0, 32'd0);
    write_reg(REG_STRATEGY, 32'(STRAT_BUMP));
    send_request(OP_ALLOC, 32'h1000_0000, 32'd0);
    send_request(OP_ALLOC, 32'hF000_0000, 32'd0);
    send_request(OP_FREE, 32'd0, 32'h1000_0000);
    set_heap(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'd1, 32'd0);
  endtask

  task automatic test_strategy(input logic [1:0] strat, input int rounds, input int n);
    for (int r = 0; r < rounds; r++) begin
      set_small_heap();
      write_reg(REG_STRATEGY, 32'(strat));
      random_traffic(n, (r % 2) ? 70 : 50);
    end
  endtask

  // switching modes leaves overlapping and duplicate extents behind
  task automatic test_mixed_modes();
    logic [1:0] modes[4] = '{STRAT_BUMP, STRAT_FIRST, STRAT_NEXT, STRAT_RSVD};
    set_small_heap();
    for (int r = 0; r < 16; r++) begin
      write_reg(REG_STRATEGY, 32'(modes[$urandom_range(0, 3)]));
      random_traffic(20, 60);
    end
    set_heap(HEAP_START_RST, HEAP_END_RST);
    for (int r = 0; r < 6; r++) begin
      write_reg(REG_STRATEGY, 32'(modes[r % 3]));
      random_traffic(20, 55);
    end
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    set_small_heap();
    write_reg(REG_STRATEGY, 32'(STRAT_NEXT));
    random_traffic(100, 60);
    write_reg(REG_STRATEGY, 32'(STRAT_FIRST));
    random_traffic(60, 60);
  endtask

  always begin
    int stall;
    stall = 0;
    @(negedge clk_i);
    if (calm || !rst_ni) begin
      out_ready_i <= 1'b1;
    end else if (stall > 0) begin
      stall--;
    end else if ($urandom_range(0, 5) == 0) begin
      stall = $urandom_range(1, 14);
      out_ready_i <= 1'b0;
      repeat (stall) @(negedge clk_i);
      stall = 0;
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: start_address=%h status=%0d", start_address_o, status_o);
      end else begin
        g = pending_grants.pop_front();
        if (start_address_o !== g.addr || status_o !== g.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: start_address exp %h got %h, status exp %0d got %0d",
                     results_seen, g.addr, start_address_o, g.st, status_o);
        end
      end
    end
  end

  initial begin
    #50000000;
    $display("timeout waiting for results, %0d still pending", pending_grants.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    mdl_strategy = STRAT_BUMP;
    mdl_heap_lo  = HEAP_START_RST;
    mdl_heap_hi  = HEAP_END_RST;
    rebuild_heap();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_corner_requests();
    test_strategy(STRAT_BUMP, 3, 80);
    test_strategy(STRAT_FIRST, 4, 100);
    test_strategy(STRAT_NEXT, 4, 100);
    test_mixed_modes();
    test_back_to_back();
    wait_drained();
    repeat (300) @(posedge clk_i);
    $display("checked %0d results: %0d grants, %0d frees, %0d no-fit, %0d table-full,",
             results_seen, n_grant, n_free_ok, n_nofit, n_full);
    $display("%0d unknown frees over bump, first-fit, next-fit and reserved modes; %0d mismatches",
             n_notfound, mismatches + pending_grants.size());
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pea_pkg.sv
rtl/pea_cell.sv
rtl/pea_ctrl.sv
rtl/page_extent_allocator.sv
tb/tb.sv
